// File: rtl/rotary_knob_input_qualifier_core_defines.svh
// Assertion macros used by the knob qualifier core.
`ifndef ROTARY_KNOB_INPUT_QUALIFIER_CORE_DEFINES_SVH
`define ROTARY_KNOB_INPUT_QUALIFIER_CORE_DEFINES_SVH

// Checks that the antecedent implies the consequent in the same cycle.
`define RKIQ_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("knob qualifier assertion failed");

// Checks that the expression is never true outside reset.
`define RKIQ_ASSERT_NEVER(lbl, ck, rn, expr) \
  lbl: assert property (@(posedge ck) disable iff (!rn) !(expr)) \
    else $error("knob qualifier assertion failed");

`endif

// File: rtl/rkiq_pkg.sv
// Shared constants and types of the rotary knob input qualifier.
package rkiq_pkg;

  localparam int KNOB_SLOTS = 3;
  localparam int KNOB_COUNT = 3;

  localparam int POS_W      = 8;
  localparam int TIMER_W    = 16;
  localparam int THR_W      = 7;
  localparam int CNT_W      = 9;
  localparam int SEL_W      = 8;
  localparam int WORD_W     = 27;
  localparam int PRESS_BASE = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};
  localparam logic [CNT_W-1:0]   CNT_MAX   = CNT_W'(256);
  localparam logic [CNT_W-1:0]   CNT_MIN   = CNT_W'(1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_THRESHOLD     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_CLICK_TICKS = 2'd2;

  // Item operation codes.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef struct packed {
    logic adv;
    logic tick;
  } knob_cmd_t;

  typedef struct packed {
    logic [POS_W-1:0] delta;
    logic             pressed;
    logic             press_edge;
    logic             dbl;
  } knob_res_t;

endpackage

// File: rtl/rotary_knob_input_qualifier_core.sv
// Top level of the rotary knob input qualifier: registers, knob units and result stage.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall   | in_op, in_knobs_word
//   out_    | output    | out_valid/out_stall | deltas, press flags, selected index
//   cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One transaction per cycle is sustained while out_stall is low; each one is held in the
// input register, then in the result register, which loads whenever advance is high.
// Reset (rst_n low, synchronous) clears all knob state, the selection and the
// configuration registers to their defaults.
// in_stall rises only when both the input register and the result register hold
// transactions and out_stall is high; cfg_ready is always high.
`include "rotary_knob_input_qualifier_core_defines.svh"
module rotary_knob_input_qualifier_core
  import rkiq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_op,
  input  logic [WORD_W-1:0]      in_knobs_word,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [POS_W-1:0] out_delta_knob0,
  output logic signed [POS_W-1:0] out_delta_knob1,
  output logic signed [POS_W-1:0] out_delta_knob2,
  output logic [KNOB_SLOTS-1:0]  out_pressed_now,
  output logic [KNOB_SLOTS-1:0]  out_press_edges,
  output logic [KNOB_SLOTS-1:0]  out_double_clicks,
  output logic [SEL_W-1:0]       out_selected_index,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [THR_W-1:0]   step_threshold_r;
  logic [CNT_W-1:0]   entry_count_r;
  logic [TIMER_W-1:0] double_click_ticks_r;

  logic              s1_valid_r;
  logic              s1_op_r;
  logic [WORD_W-1:0] s1_word_r;
  logic              out_valid_r;
  logic              advance;
  knob_cmd_t         cmd;

  knob_res_t        res [KNOB_SLOTS];
  logic [SEL_W-1:0] sel_nxt;

  logic [POS_W-1:0]      delta_r [KNOB_SLOTS];
  logic [KNOB_SLOTS-1:0] pressed_r, edges_r, doubles_r;
  logic [SEL_W-1:0]      sel_out_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_threshold_r     <= THR_W'(2);
      entry_count_r        <= CNT_MIN;
      double_click_ticks_r <= TIMER_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_STEP_THRESHOLD:     step_threshold_r     <= cfg_data[THR_W-1:0];
        CFG_ENTRY_COUNT:        entry_count_r        <= cfg_data[CNT_W-1:0];
        CFG_DOUBLE_CLICK_TICKS: double_click_ticks_r <= cfg_data[TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  // The input register moves on whenever the result register is free or draining.
  assign advance  = s1_valid_r && !(out_valid_r && out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign cmd.adv  = advance;
  assign cmd.tick = (s1_op_r == OP_TICK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_op_r   <= in_op;
      s1_word_r <= in_knobs_word;
    end
  end

  for (genvar i = 0; i < KNOB_SLOTS; i++) begin : g_knob
    if (i < KNOB_COUNT) begin : g_on
      rkiq_knob u_knob (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .pos   (s1_word_r[POS_W*i +: POS_W]),
        .pr    (s1_word_r[PRESS_BASE+i]),
        .dct   (double_click_ticks_r),
        .res   (res[i])
      );
    end else begin : g_off
      assign res[i] = '0;
    end
  end

  rkiq_sel u_sel (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .delta1      (res[1].delta),
    .thr         (step_threshold_r),
    .entry_count (entry_count_r),
    .sel_nxt     (sel_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < KNOB_SLOTS; i++) begin
        delta_r[i]   <= res[i].delta;
        pressed_r[i] <= res[i].pressed;
        edges_r[i]   <= res[i].press_edge;
        doubles_r[i] <= res[i].dbl;
      end
      sel_out_r <= sel_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_delta_knob0    = $signed(delta_r[0]);
  assign out_delta_knob1    = $signed(delta_r[1]);
  assign out_delta_knob2    = $signed(delta_r[2]);
  assign out_pressed_now    = pressed_r;
  assign out_press_edges    = edges_r;
  assign out_double_clicks  = doubles_r;
  assign out_selected_index = sel_out_r;

  // A double click is always also a press edge, and an edge means the knob is pressed.
  `RKIQ_ASSERT_IMPL(a_dbl_is_edge, clk, rst_n, out_valid_r, (doubles_r & ~edges_r) == '0)
  `RKIQ_ASSERT_IMPL(a_edge_is_pressed, clk, rst_n, out_valid_r, (edges_r & ~pressed_r) == '0)
  `RKIQ_ASSERT_IMPL(a_stall_needs_full, clk, rst_n, in_stall, s1_valid_r && out_valid_r)
  `RKIQ_ASSERT_NEVER(a_no_adv_empty, clk, rst_n, advance && !s1_valid_r)

endmodule

// File: rtl/rkiq_knob.sv
// State and qualification logic for one knob: delta, press edge and double click.
module rkiq_knob
  import rkiq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  knob_cmd_t          cmd,
  input  logic [POS_W-1:0]   pos,
  input  logic               pr,
  input  logic [TIMER_W-1:0] dct,
  output knob_res_t          res
);

  logic [POS_W-1:0]   last_pos_r, last_pos_nxt;
  logic               last_pr_r, last_pr_nxt;
  logic               await_r, await_nxt;
  logic [TIMER_W-1:0] timer_r, timer_nxt;
  logic [TIMER_W-1:0] timer_inc;
  logic               press_edge;
  logic               dbl;

  always_comb begin
    timer_inc    = (timer_r == TIMER_MAX) ? timer_r : timer_r + 1'b1;
    press_edge   = !cmd.tick && pr && !last_pr_r;
    last_pos_nxt = last_pos_r;
    last_pr_nxt  = last_pr_r;
    await_nxt    = await_r;
    timer_nxt    = timer_r;
    dbl          = 1'b0;
    if (cmd.tick) begin
      timer_nxt = timer_inc;
      await_nxt = await_r && !(timer_inc > dct);
    end else begin
      last_pos_nxt = pos;
      last_pr_nxt  = pr;
      if (press_edge) begin
        // The timer is read before it restarts; an edge that comes while waiting ends the wait.
        dbl       = await_r && (timer_r < dct);
        await_nxt = !await_r;
        timer_nxt = '0;
      end else begin
        await_nxt = await_r && !(timer_r > dct);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pos_r <= '0;
      last_pr_r  <= 1'b0;
      await_r    <= 1'b0;
      timer_r    <= '0;
    end else if (cmd.adv) begin
      last_pos_r <= last_pos_nxt;
      last_pr_r  <= last_pr_nxt;
      await_r    <= await_nxt;
      timer_r    <= timer_nxt;
    end
  end

  assign res.delta      = cmd.tick ? '0 : pos - last_pos_r;
  assign res.pressed    = last_pr_nxt;
  assign res.press_edge = press_edge;
  assign res.dbl        = dbl;

endmodule

// File: rtl/rkiq_sel.sv
// Wrapping selection index stepped by the signed change of knob 1.
module rkiq_sel
  import rkiq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  knob_cmd_t        cmd,
  input  logic [POS_W-1:0] delta1,
  input  logic [THR_W-1:0] thr,
  input  logic [CNT_W-1:0] entry_count,
  output logic [SEL_W-1:0] sel_nxt
);

  logic [SEL_W-1:0] sel_r;
  logic [CNT_W-1:0] eff_count;
  logic [SEL_W-1:0] sel_up;
  logic signed [POS_W:0] d_ext;
  logic signed [POS_W:0] thr_pos;
  logic signed [POS_W:0] thr_neg;

  always_comb begin
    if (entry_count == '0) begin
      eff_count = CNT_MIN;
    end else if (entry_count > CNT_MAX) begin
      eff_count = CNT_MAX;
    end else begin
      eff_count = entry_count;
    end
    d_ext   = $signed({delta1[POS_W-1], delta1});
    thr_pos = $signed({{(POS_W+1-THR_W){1'b0}}, thr});
    thr_neg = -thr_pos;
    sel_up  = sel_r + 1'b1;
    sel_nxt = sel_r;
    if (!cmd.tick) begin
      if (d_ext > thr_pos) begin
        sel_nxt = ({1'b0, sel_up} >= eff_count) ? '0 : sel_up;
      end else if (d_ext < thr_neg) begin
        // A step down wraps only from zero; a stale high index just decrements.
        if (sel_r == '0) begin
          sel_nxt = SEL_W'(eff_count - 1'b1);
        end else begin
          sel_nxt = sel_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= '0;
    end else if (cmd.adv) begin
      sel_r <= sel_nxt;
    end
  end

endmodule
